/* hw/rtl/mixer_volume_command_translator_assert.svh */
// Assertion macros for the mixer volume command translator.
// Expects clk and rst in scope at the point of use.
`ifndef MIXER_VOLUME_COMMAND_TRANSLATOR_ASSERT_SVH
`define MIXER_VOLUME_COMMAND_TRANSLATOR_ASSERT_SVH

// same-cycle implication
`define MVCT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mvct assertion failed");

// next-cycle implication
`define MVCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mvct assertion failed");

`endif

/* hw/rtl/mvct_pkg.sv */
// Types, opcode tables and scaling helpers for the mixer volume command translator.
// No dependencies.
package mvct_pkg;

  typedef enum logic [1:0] {
    ACT_SET_VOLUME = 2'd0,
    ACT_GET_VOLUME = 2'd1,
    ACT_SET_SOLO   = 2'd2,
    ACT_QUERY_SOLO = 2'd3
  } action_t;

  localparam logic [3:0] CH_PREAMP           = 4'd8;
  localparam logic [7:0] PCT_FULL            = 8'd100;
  localparam logic [5:0] ATT_FULL            = 6'd32;
  localparam logic [7:0] GAIN_FULL           = 8'd3;
  localparam logic [7:0] SOLO_OPCODE         = 8'hd2;
  localparam logic [7:0] NEW_FIRMWARE        = 8'hb0;
  localparam logic [7:0] PREAMP_READ_INDEX   = 8'h21;
  localparam logic [7:0] PREAMP_WRITE_OPCODE = 8'h03;
  localparam logic [1:0] CMD_NONE            = 2'd0;
  localparam logic [1:0] CMD_ONE             = 2'd1;
  localparam logic [1:0] CMD_TWO             = 2'd2;

  // floor(x/100) for x < 4096: multiply by ceil(2^19/100), shift by 19
  localparam logic [12:0] DIV100_MUL = 13'd5243;

  localparam logic [7:0] WR_LEFT [8] = '{8'h01, 8'h3c, 8'h38, 8'h39,
                                          8'h3b, 8'h3a, 8'h3d, 8'h3e};
  localparam logic [7:0] WR_RIGHT [8] = '{8'h00, 8'h34, 8'h30, 8'h31,
                                           8'h33, 8'h32, 8'h35, 8'h36};
  localparam logic [7:0] RD_LEFT [8] = '{8'h04, 8'h0a, 8'h06, 8'h08,
                                          8'h0c, 8'h0e, 8'h11, 8'h13};
  localparam logic [7:0] RD_RIGHT [8] = '{8'h03, 8'h09, 8'h05, 8'h07,
                                           8'h0b, 8'h0d, 8'h10, 8'h12};

  typedef struct packed {
    logic [7:0] left_opcode;
    logic [7:0] left_param;
    logic [7:0] right_opcode;
    logic [7:0] right_param;
    logic [1:0] command_count;
    logic [6:0] left_volume;
    logic [6:0] right_volume;
    logic       solo_state;
    logic       error;
  } result_t;

  function automatic logic [6:0] clamp_pct(input logic [7:0] v);
    return (v > PCT_FULL) ? PCT_FULL[6:0] : v[6:0];
  endfunction

  function automatic logic [5:0] div100(input logic [11:0] x);
    logic [24:0] prod;
    prod = {1'b0, x} * {12'd0, DIV100_MUL};
    return prod[24:19];
  endfunction

  // round(level*32/100), level <= 100
  function automatic logic [5:0] level_to_step(input logic [6:0] lvl);
    return div100({lvl, 5'd0} + 12'd50);
  endfunction

  // round(step*100/32), step <= 32
  function automatic logic [6:0] step_to_pct(input logic [5:0] s);
    logic [12:0] t;
    t = {7'd0, s} * 13'd100 + 13'd16;
    return t[11:5];
  endfunction

  // round(level*3/100), level <= 100
  function automatic logic [1:0] level_to_gain(input logic [6:0] lvl);
    logic [5:0] q;
    q = div100({5'd0, lvl} * 12'd3 + 12'd50);
    return q[1:0];
  endfunction

  // round(gain*100/3)
  function automatic logic [6:0] gain_to_pct(input logic [1:0] g);
    logic [6:0] p;
    case (g)
      2'd0:    p = 7'd0;
      2'd1:    p = 7'd33;
      2'd2:    p = 7'd67;
      default: p = 7'd100;
    endcase
    return p;
  endfunction

  // attenuation byte read back -> percent; 0x20 and up is silence
  function automatic logic [6:0] att_to_pct(input logic [7:0] b);
    logic [5:0] s;
    s = (b < {2'd0, ATT_FULL}) ? (ATT_FULL - {1'b0, b[4:0]}) : 6'd0;
    return step_to_pct(s);
  endfunction

endpackage

/* hw/rtl/mixer_volume_command_translator.sv */
// Mixer volume command translator: request register, translation logic, result register.
// Depends on mvct_pkg and mixer_volume_command_translator_assert.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one mixer request: action, channel,
//   requested levels, raw bytes read back from the controller, solo request and
//   the controller's general status. A request is taken on an edge with in_valid
//   high and in_stall low.
//   Output channel (out_valid / out_stall) carries one result per request: the
//   command opcodes and parameter bytes, the command count, the resulting
//   volumes, the solo state and an error flag for a bad channel.
//   cfg_we / cfg_wdata write the firmware version; write it only while idle.
// A request passes through the request register and then the result register.
// Throughput: 1 request per cycle while out_stall is low; the translation is one pass
//   of constant-divisor scaling and table lookups between the two registers.
// Stall: while out_stall holds, the result stays put; one more request can still
//   be taken into the request register, after which in_stall rises.
// Reset: rst (synchronous) empties both registers, clears the solo flag and sets
//   the firmware version to 0.
`include "mixer_volume_command_translator_assert.svh"

module mixer_volume_command_translator
  import mvct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [3:0] channel,
  input  logic [7:0] left_level,
  input  logic [7:0] right_level,
  input  logic [7:0] left_raw,
  input  logic [7:0] right_raw,
  input  logic       solo_request,
  input  logic [7:0] general_status,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] left_opcode,
  output logic [7:0] left_param,
  output logic [7:0] right_opcode,
  output logic [7:0] right_param,
  output logic [1:0] command_count,
  output logic [6:0] left_volume,
  output logic [6:0] right_volume,
  output logic       solo_state,
  output logic       error
);

  // configuration and kept state
  logic [7:0] firmware_version;
  logic       solo_flag;
  logic       solo_flag_next;

  // request register
  logic       s1_valid;
  action_t    s1_action;
  logic [3:0] s1_channel;
  logic [7:0] s1_left_level;
  logic [7:0] s1_right_level;
  logic [7:0] s1_left_raw;
  logic [7:0] s1_right_raw;
  logic       s1_solo_request;
  logic [7:0] s1_general_status;
  logic       s1_advance;

  // result register
  result_t    res;
  result_t    res_next;

  // intermediate scaling values
  logic [5:0] step_l;
  logic [5:0] step_r;
  logic [1:0] gain_set;
  logic [1:0] gain_read;
  logic [2:0] ch_idx;

  // request register moves forward when the result slot is free or being taken
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      firmware_version <= 8'd0;
    end else if (cfg_we) begin
      firmware_version <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action         <= action_t'(action);
      s1_channel        <= channel;
      s1_left_level     <= left_level;
      s1_right_level    <= right_level;
      s1_left_raw       <= left_raw;
      s1_right_raw      <= right_raw;
      s1_solo_request   <= solo_request;
      s1_general_status <= general_status;
    end
  end

  // solo flag changes as the set-solo request passes into the result register,
  // so any later query sees it while the firmware version is below NEW_FIRMWARE
  always_ff @(posedge clk) begin
    if (rst) begin
      solo_flag <= 1'b0;
    end else if (s1_advance) begin
      solo_flag <= solo_flag_next;
    end
  end

  always_comb begin
    ch_idx    = s1_channel[2:0];
    step_l    = level_to_step(clamp_pct(s1_left_level));
    step_r    = level_to_step(clamp_pct(s1_right_level));
    gain_set  = level_to_gain(clamp_pct(s1_left_level));
    gain_read = (s1_left_raw > GAIN_FULL) ? GAIN_FULL[1:0] : s1_left_raw[1:0];

    res_next       = '0;
    solo_flag_next = solo_flag;

    case (s1_action)
      ACT_SET_VOLUME: begin
        if (!s1_channel[3]) begin
          res_next.left_opcode   = WR_LEFT[ch_idx];
          res_next.left_param    = {2'd0, ATT_FULL - step_l};
          res_next.right_opcode  = WR_RIGHT[ch_idx];
          res_next.right_param   = {2'd0, ATT_FULL - step_r};
          res_next.command_count = CMD_TWO;
          res_next.left_volume   = step_to_pct(step_l);
          res_next.right_volume  = step_to_pct(step_r);
        end else if (s1_channel == CH_PREAMP) begin
          // preamp: one write with a 0..3 gain
          res_next.left_opcode   = PREAMP_WRITE_OPCODE;
          res_next.left_param    = {6'd0, gain_set};
          res_next.command_count = CMD_ONE;
          res_next.left_volume   = gain_to_pct(gain_set);
          res_next.right_volume  = gain_to_pct(gain_set);
        end else begin
          res_next.error = 1'b1;
        end
      end
      ACT_GET_VOLUME: begin
        if (!s1_channel[3]) begin
          res_next.left_opcode   = RD_LEFT[ch_idx];
          res_next.right_opcode  = RD_RIGHT[ch_idx];
          res_next.command_count = CMD_TWO;
          res_next.left_volume   = att_to_pct(s1_left_raw);
          res_next.right_volume  = att_to_pct(s1_right_raw);
        end else if (s1_channel == CH_PREAMP) begin
          res_next.left_opcode   = PREAMP_READ_INDEX;
          res_next.command_count = CMD_ONE;
          res_next.left_volume   = gain_to_pct(gain_read);
          res_next.right_volume  = gain_to_pct(gain_read);
        end else begin
          res_next.error = 1'b1;
        end
      end
      ACT_SET_SOLO: begin
        solo_flag_next         = s1_solo_request;
        res_next.left_opcode   = SOLO_OPCODE;
        res_next.left_param    = {7'd0, s1_solo_request};
        res_next.command_count = CMD_ONE;
        res_next.solo_state    = s1_solo_request;
      end
      ACT_QUERY_SOLO: begin
        // newer firmware reports solo in status bit 5, active low
        if (firmware_version >= NEW_FIRMWARE) begin
          res_next.solo_state = !s1_general_status[5];
        end else begin
          res_next.solo_state = solo_flag;
        end
        res_next.command_count = CMD_NONE;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res <= res_next;
    end
  end

  assign left_opcode   = res.left_opcode;
  assign left_param    = res.left_param;
  assign right_opcode  = res.right_opcode;
  assign right_param   = res.right_param;
  assign command_count = res.command_count;
  assign left_volume   = res.left_volume;
  assign right_volume  = res.right_volume;
  assign solo_state    = res.solo_state;
  assign error         = res.error;

  // a rejected channel produces no controller command
  `MVCT_ASSERT_IMPL(a_error_no_cmd, out_valid && error, command_count == CMD_NONE && left_opcode == 8'd0)
  // input only backs up when both registers are full and the receiver stalls
  `MVCT_ASSERT_IMPL(a_stall_cause, in_stall, s1_valid && out_valid && out_stall)
  // a set-solo request passing through updates the kept flag
  `MVCT_ASSERT_NEXT(a_solo_update, s1_advance && s1_action == ACT_SET_SOLO, solo_flag == $past(s1_solo_request))

endmodule
